### hw/rtl/ctsp_pkg.sv
`timescale 1ns / 1ps
package ctsp_pkg;

    localparam int TXID_BYTES = 32;
    localparam int MAX_RESULTS = 3;
    localparam logic [7:0] MIN_TX_RESET = 8'd60;

    typedef enum logic [4:0] {
        PH_VERSION, PH_MARKER, PH_FLAG, PH_INCOUNT, PH_TXID, PH_PREVIDX,
        PH_SIGLEN, PH_SIGSKIP, PH_SEQ, PH_OUTCOUNT, PH_AMOUNT, PH_PKLEN,
        PH_PKSKIP, PH_WITCOUNT, PH_WITLEN, PH_WITSKIP, PH_LOCKTIME, PH_TRAIL,
        PH_ERROR
    } t_phase;

    typedef enum logic [3:0] {
        K_VERSION, K_WITNESS, K_INCOUNT, K_TXID, K_PREVIDX, K_SIGLEN, K_SEQ,
        K_OUTCOUNT, K_AMOUNT, K_PKLEN, K_WITCOUNT, K_WITLEN, K_LOCKTIME,
        K_DONE, K_ERROR
    } t_kind;

    typedef enum logic [2:0] {
        E_NONE, E_SHORT, E_EARLY, E_TRAILING, E_TOO_LARGE
    } t_err;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_tx;
    } t_in_item;

    typedef struct packed {
        t_kind       field_kind;
        logic [63:0] field_value;
        logic [31:0] entry_number;
        logic [4:0]  byte_position;
        t_err        error_code;
        logic        run_last;
    } t_out_item;

    // all results caused by one byte
    typedef struct packed {
        logic [1:0]                       count;
        t_out_item [MAX_RESULTS-1:0]      items;
    } t_bundle;

endpackage

### hw/rtl/ctsp_front.sv
`timescale 1ns / 1ps
module ctsp_front #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ctsp_pkg::t_in_item i_data,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_q_ready,
    output logic              o_push,
    output ctsp_pkg::t_bundle o_bundle
);

    localparam int CW = COUNT_WIDTH;
    localparam logic [5:0] TXID_LAST = 6'(ctsp_pkg::TXID_BYTES - 1);

    ctsp_pkg::t_phase r_phase, n_phase;
    logic [5:0]    r_fbc, n_fbc;
    logic [63:0]   r_acc, n_acc;
    logic [3:0]    r_vw, n_vw;
    logic [31:0]   r_total, n_total;
    logic [CW-1:0] r_in_tot, n_in_tot;
    logic [CW-1:0] r_cur, n_cur;
    logic [CW-1:0] r_out_tot, n_out_tot;
    logic [CW-1:0] r_skip, n_skip;
    logic [CW-1:0] r_wleft, n_wleft;
    logic [CW-1:0] r_witem, n_witem;
    logic          r_wpres, n_wpres;
    logic          r_pend, n_pend;
    logic [7:0]    r_min;

    logic                       accept;
    logic [7:0]                 b;
    ctsp_pkg::t_phase           ep;
    logic                       vdone;
    logic [63:0]                vacc;
    logic [5:0]                 vfbc;
    logic [3:0]                 vvw;
    logic                       vfits;
    logic [CW-1:0]              vcnt;
    logic [63:0]                facc;
    logic [5:0]                 finc;
    logic [CW-1:0]              cur_inc;
    logic [CW-1:0]              skip_dec;
    logic                       e_valid [4];
    ctsp_pkg::t_out_item        e_item  [4];
    logic [1:0]                 slot;

    function automatic ctsp_pkg::t_out_item mk(ctsp_pkg::t_kind k, logic [63:0] v,
                                               logic [31:0] ent, logic [4:0] pos,
                                               ctsp_pkg::t_err err);
        ctsp_pkg::t_out_item it;
        it.field_kind    = k;
        it.field_value   = v;
        it.entry_number  = ent;
        it.byte_position = pos;
        it.error_code    = err;
        it.run_last      = 1'b0;
        return it;
    endfunction

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;
    assign b       = i_data.data_byte;

    // CompactSize and fixed-width field assembly
    always_comb begin
        vacc  = r_acc;
        vfbc  = r_fbc;
        vvw   = r_vw;
        vdone = 1'b0;
        if (r_fbc == 6'd0) begin
            if (b < 8'hFD) begin
                vacc  = {56'd0, b};
                vdone = 1'b1;
            end else begin
                vvw  = (b == 8'hFD) ? 4'd2 : (b == 8'hFE) ? 4'd4 : 4'd8;
                vacc = 64'd0;
                vfbc = 6'd1;
            end
        end else begin
            vacc = r_acc | ({56'd0, b} << {(r_fbc[2:0] - 3'd1), 3'b000});
            vfbc = r_fbc + 6'd1;
            if (r_fbc >= {2'b00, r_vw}) begin
                vdone = 1'b1;
                vfbc  = 6'd0;
            end
        end
        vfits = (CW >= 64) ? 1'b1 : ((vacc >> CW) == 64'd0);
        vcnt  = CW'(vacc);
        facc  = ((r_fbc == 6'd0) ? 64'd0 : r_acc) | ({56'd0, b} << {r_fbc[2:0], 3'b000});
        finc  = r_fbc + 6'd1;
    end

    assign cur_inc  = r_cur + CW'(1);
    assign skip_dec = r_skip - CW'(1);

    // next state and results for one byte
    always_comb begin
        n_phase   = r_phase;
        n_fbc     = r_fbc;
        n_acc     = r_acc;
        n_vw      = r_vw;
        n_in_tot  = r_in_tot;
        n_cur     = r_cur;
        n_out_tot = r_out_tot;
        n_skip    = r_skip;
        n_wleft   = r_wleft;
        n_witem   = r_witem;
        n_wpres   = r_wpres;
        n_pend    = r_pend;
        n_total   = (r_total == 32'hFFFF_FFFF) ? r_total : r_total + 32'd1;
        for (int i = 0; i < 4; i++) begin
            e_valid[i] = 1'b0;
            e_item[i]  = mk(ctsp_pkg::K_VERSION, 64'd0, 32'd0, 5'd0, ctsp_pkg::E_NONE);
        end

        // redirect marker and flag bytes that turn out to be counts
        ep = r_phase;
        if (r_phase == ctsp_pkg::PH_MARKER && b != 8'd0) begin
            ep      = ctsp_pkg::PH_INCOUNT;
            n_phase = ctsp_pkg::PH_INCOUNT;
        end
        if (r_phase == ctsp_pkg::PH_FLAG && b != 8'd1) begin
            ep       = ctsp_pkg::PH_OUTCOUNT;
            n_phase  = ctsp_pkg::PH_OUTCOUNT;
            n_pend   = 1'b0;
            n_in_tot = '0;
            e_valid[0] = 1'b1;
            e_item[0]  = mk(ctsp_pkg::K_INCOUNT, 64'd0, 32'd0, 5'd0, ctsp_pkg::E_NONE);
        end

        case (ep)
            ctsp_pkg::PH_VERSION, ctsp_pkg::PH_PREVIDX, ctsp_pkg::PH_SEQ,
            ctsp_pkg::PH_AMOUNT, ctsp_pkg::PH_LOCKTIME: begin
                n_acc = facc;
                n_fbc = finc;
                if (finc >= ((ep == ctsp_pkg::PH_AMOUNT) ? 6'd8 : 6'd4)) begin
                    n_fbc = 6'd0;
                    e_valid[1] = 1'b1;
                    case (ep)
                        ctsp_pkg::PH_VERSION: begin
                            e_item[1] = mk(ctsp_pkg::K_VERSION, facc, 32'd0, 5'd0,
                                           ctsp_pkg::E_NONE);
                            n_phase = ctsp_pkg::PH_MARKER;
                        end
                        ctsp_pkg::PH_PREVIDX: begin
                            e_item[1] = mk(ctsp_pkg::K_PREVIDX, facc, 32'(r_cur), 5'd0,
                                           ctsp_pkg::E_NONE);
                            n_phase = ctsp_pkg::PH_SIGLEN;
                        end
                        ctsp_pkg::PH_SEQ: begin
                            e_item[1] = mk(ctsp_pkg::K_SEQ, facc, 32'(r_cur), 5'd0,
                                           ctsp_pkg::E_NONE);
                            if (cur_inc >= r_in_tot) begin
                                n_cur   = '0;
                                n_phase = ctsp_pkg::PH_OUTCOUNT;
                            end else begin
                                n_cur   = cur_inc;
                                n_phase = ctsp_pkg::PH_TXID;
                            end
                        end
                        ctsp_pkg::PH_AMOUNT: begin
                            e_item[1] = mk(ctsp_pkg::K_AMOUNT, facc, 32'(r_cur), 5'd0,
                                           ctsp_pkg::E_NONE);
                            n_phase = ctsp_pkg::PH_PKLEN;
                        end
                        default: begin
                            e_item[1] = mk(ctsp_pkg::K_LOCKTIME, facc, 32'd0, 5'd0,
                                           ctsp_pkg::E_NONE);
                            n_phase = ctsp_pkg::PH_TRAIL;
                        end
                    endcase
                end
            end
            ctsp_pkg::PH_MARKER: begin
                n_pend  = 1'b1;
                n_phase = ctsp_pkg::PH_FLAG;
            end
            ctsp_pkg::PH_FLAG: begin
                n_pend     = 1'b0;
                n_wpres    = 1'b1;
                e_valid[1] = 1'b1;
                e_item[1]  = mk(ctsp_pkg::K_WITNESS, 64'd1, 32'd0, 5'd0, ctsp_pkg::E_NONE);
                n_phase    = ctsp_pkg::PH_INCOUNT;
            end
            ctsp_pkg::PH_TXID: begin
                e_valid[1] = 1'b1;
                e_item[1]  = mk(ctsp_pkg::K_TXID, {56'd0, b}, 32'(r_cur),
                                5'(TXID_LAST - r_fbc), ctsp_pkg::E_NONE);
                n_fbc = finc;
                if (finc >= 6'(ctsp_pkg::TXID_BYTES)) begin
                    n_fbc   = 6'd0;
                    n_phase = ctsp_pkg::PH_PREVIDX;
                end
            end
            ctsp_pkg::PH_INCOUNT, ctsp_pkg::PH_SIGLEN, ctsp_pkg::PH_OUTCOUNT,
            ctsp_pkg::PH_PKLEN, ctsp_pkg::PH_WITCOUNT, ctsp_pkg::PH_WITLEN: begin
                n_acc = vacc;
                n_fbc = vfbc;
                n_vw  = vvw;
                if (vdone) begin
                    e_valid[1] = 1'b1;
                    if (!vfits) begin
                        e_item[1] = mk(ctsp_pkg::K_ERROR, {32'd0, n_total}, 32'd0, 5'd0,
                                       ctsp_pkg::E_TOO_LARGE);
                        n_phase = ctsp_pkg::PH_ERROR;
                    end else begin
                        case (ep)
                            ctsp_pkg::PH_INCOUNT: begin
                                e_item[1] = mk(ctsp_pkg::K_INCOUNT, vacc, 32'd0, 5'd0,
                                               ctsp_pkg::E_NONE);
                                n_in_tot = vcnt;
                                n_cur    = '0;
                                n_phase  = (vcnt == '0) ? ctsp_pkg::PH_OUTCOUNT
                                                        : ctsp_pkg::PH_TXID;
                            end
                            ctsp_pkg::PH_SIGLEN: begin
                                e_item[1] = mk(ctsp_pkg::K_SIGLEN, vacc, 32'(r_cur), 5'd0,
                                               ctsp_pkg::E_NONE);
                                n_skip  = vcnt;
                                n_phase = (vcnt == '0) ? ctsp_pkg::PH_SEQ
                                                       : ctsp_pkg::PH_SIGSKIP;
                            end
                            ctsp_pkg::PH_OUTCOUNT: begin
                                e_item[1] = mk(ctsp_pkg::K_OUTCOUNT, vacc, 32'd0, 5'd0,
                                               ctsp_pkg::E_NONE);
                                n_out_tot = vcnt;
                                n_cur     = '0;
                                if (vcnt == '0) begin
                                    n_phase = (n_wpres && n_in_tot != '0)
                                              ? ctsp_pkg::PH_WITCOUNT
                                              : ctsp_pkg::PH_LOCKTIME;
                                end else begin
                                    n_phase = ctsp_pkg::PH_AMOUNT;
                                end
                            end
                            ctsp_pkg::PH_PKLEN: begin
                                e_item[1] = mk(ctsp_pkg::K_PKLEN, vacc, 32'(r_cur), 5'd0,
                                               ctsp_pkg::E_NONE);
                                n_skip = vcnt;
                                if (vcnt != '0) begin
                                    n_phase = ctsp_pkg::PH_PKSKIP;
                                end else if (cur_inc >= r_out_tot) begin
                                    n_cur   = '0;
                                    n_phase = (r_wpres && r_in_tot != '0)
                                              ? ctsp_pkg::PH_WITCOUNT
                                              : ctsp_pkg::PH_LOCKTIME;
                                end else begin
                                    n_cur   = cur_inc;
                                    n_phase = ctsp_pkg::PH_AMOUNT;
                                end
                            end
                            ctsp_pkg::PH_WITCOUNT: begin
                                e_item[1] = mk(ctsp_pkg::K_WITCOUNT, vacc, 32'(r_cur), 5'd0,
                                               ctsp_pkg::E_NONE);
                                n_wleft = vcnt;
                                n_witem = '0;
                                if (vcnt != '0) begin
                                    n_phase = ctsp_pkg::PH_WITLEN;
                                end else begin
                                    n_cur   = cur_inc;
                                    n_phase = (cur_inc >= r_in_tot) ? ctsp_pkg::PH_LOCKTIME
                                                                    : ctsp_pkg::PH_WITCOUNT;
                                end
                            end
                            default: begin
                                e_item[1] = mk(ctsp_pkg::K_WITLEN, vacc, 32'(r_witem), 5'd0,
                                               ctsp_pkg::E_NONE);
                                n_witem = r_witem + CW'(1);
                                n_wleft = r_wleft - CW'(1);
                                n_skip  = vcnt;
                                if (vcnt != '0) begin
                                    n_phase = ctsp_pkg::PH_WITSKIP;
                                end else if (n_wleft != '0) begin
                                    n_phase = ctsp_pkg::PH_WITLEN;
                                end else begin
                                    n_cur   = cur_inc;
                                    n_phase = (cur_inc >= r_in_tot) ? ctsp_pkg::PH_LOCKTIME
                                                                    : ctsp_pkg::PH_WITCOUNT;
                                end
                            end
                        endcase
                    end
                end
            end
            ctsp_pkg::PH_SIGSKIP: begin
                n_skip = skip_dec;
                if (skip_dec == '0) begin
                    n_phase = ctsp_pkg::PH_SEQ;
                end
            end
            ctsp_pkg::PH_PKSKIP: begin
                n_skip = skip_dec;
                if (skip_dec == '0) begin
                    if (cur_inc >= r_out_tot) begin
                        n_cur   = '0;
                        n_phase = (r_wpres && r_in_tot != '0) ? ctsp_pkg::PH_WITCOUNT
                                                              : ctsp_pkg::PH_LOCKTIME;
                    end else begin
                        n_cur   = cur_inc;
                        n_phase = ctsp_pkg::PH_AMOUNT;
                    end
                end
            end
            ctsp_pkg::PH_WITSKIP: begin
                n_skip = skip_dec;
                if (skip_dec == '0) begin
                    if (r_wleft != '0) begin
                        n_phase = ctsp_pkg::PH_WITLEN;
                    end else begin
                        n_cur   = cur_inc;
                        n_phase = (cur_inc >= r_in_tot) ? ctsp_pkg::PH_LOCKTIME
                                                        : ctsp_pkg::PH_WITCOUNT;
                    end
                end
            end
            default: begin
            end
        endcase

        // end of transaction: pending zero count, then the end result
        if (i_data.end_of_tx) begin
            if (r_phase != ctsp_pkg::PH_ERROR && n_phase != ctsp_pkg::PH_ERROR) begin
                if (n_phase == ctsp_pkg::PH_FLAG && n_pend) begin
                    e_valid[2] = 1'b1;
                    e_item[2]  = mk(ctsp_pkg::K_INCOUNT, 64'd0, 32'd0, 5'd0,
                                    ctsp_pkg::E_NONE);
                end
                e_valid[3] = 1'b1;
                if (n_total < {24'd0, r_min}) begin
                    e_item[3] = mk(ctsp_pkg::K_ERROR, {32'd0, n_total}, 32'd0, 5'd0,
                                   ctsp_pkg::E_SHORT);
                end else if (r_phase == ctsp_pkg::PH_TRAIL) begin
                    e_item[3] = mk(ctsp_pkg::K_ERROR, {32'd0, n_total}, 32'd0, 5'd0,
                                   ctsp_pkg::E_TRAILING);
                end else if (n_phase != ctsp_pkg::PH_TRAIL) begin
                    e_item[3] = mk(ctsp_pkg::K_ERROR, {32'd0, n_total}, 32'd0, 5'd0,
                                   ctsp_pkg::E_EARLY);
                end else begin
                    e_item[3] = mk(ctsp_pkg::K_DONE, {32'd0, n_total}, 32'd0, 5'd0,
                                   ctsp_pkg::E_NONE);
                end
            end
            n_phase   = ctsp_pkg::PH_VERSION;
            n_fbc     = '0;
            n_acc     = '0;
            n_vw      = '0;
            n_total   = '0;
            n_in_tot  = '0;
            n_cur     = '0;
            n_out_tot = '0;
            n_skip    = '0;
            n_wleft   = '0;
            n_witem   = '0;
            n_wpres   = 1'b0;
            n_pend    = 1'b0;
        end

        // pack results in order, mark the last one
        slot = 2'd0;
        o_bundle.items = '0;
        for (int i = 0; i < 4; i++) begin
            if (e_valid[i] && slot < 2'(ctsp_pkg::MAX_RESULTS)) begin
                o_bundle.items[slot] = e_item[i];
                slot = slot + 2'd1;
            end
        end
        if (slot != 2'd0) begin
            o_bundle.items[slot - 2'd1].run_last = 1'b1;
        end
        o_bundle.count = slot;
        o_push = accept && (slot != 2'd0);
    end

    // hold parser state between beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ctsp_pkg::PH_VERSION;
            r_fbc     <= '0;
            r_acc     <= '0;
            r_vw      <= '0;
            r_total   <= '0;
            r_in_tot  <= '0;
            r_cur     <= '0;
            r_out_tot <= '0;
            r_skip    <= '0;
            r_wleft   <= '0;
            r_witem   <= '0;
            r_wpres   <= 1'b0;
            r_pend    <= 1'b0;
            r_min     <= ctsp_pkg::MIN_TX_RESET;
        end else begin
            if (i_cfg_we) begin
                r_min <= i_cfg_data;
            end
            if (accept) begin
                r_phase   <= n_phase;
                r_fbc     <= n_fbc;
                r_acc     <= n_acc;
                r_vw      <= n_vw;
                r_total   <= n_total;
                r_in_tot  <= n_in_tot;
                r_cur     <= n_cur;
                r_out_tot <= n_out_tot;
                r_skip    <= n_skip;
                r_wleft   <= n_wleft;
                r_witem   <= n_witem;
                r_wpres   <= n_wpres;
                r_pend    <= n_pend;
            end
        end
    end

endmodule

### hw/rtl/ctsp_queue.sv
`timescale 1ns / 1ps
module ctsp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ctsp_pkg::t_bundle i_bundle,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output ctsp_pkg::t_bundle o_bundle
);

    localparam int Depth = 4;

    ctsp_pkg::t_bundle r_mem [Depth];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_count;
    logic       do_push, do_pop;

    assign o_ready  = (r_count != 3'(Depth));
    assign o_valid  = (r_count != 3'd0);
    assign o_bundle = r_mem[r_rd];
    assign do_push  = i_push && o_ready;
    assign do_pop   = i_pop && o_valid;

    // store bundles
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    // advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_count <= r_count + 3'(do_push) - 3'(do_pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(Depth))
        else $error("queue occupancy above depth");

    a_push_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push && !do_pop |=> r_count == $past(r_count) + 3'd1)
        else $error("push lost");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 3'(Depth) |-> (r_wr - r_rd) == r_count[1:0])
        else $error("pointers disagree with occupancy");

endmodule

### hw/rtl/ctsp_back.sv
`timescale 1ns / 1ps
module ctsp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  ctsp_pkg::t_bundle   i_bundle,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output ctsp_pkg::t_out_item o_data
);

    logic                r_valid;
    ctsp_pkg::t_out_item r_data;
    logic [1:0]          r_idx;
    logic                load;
    logic                last;

    assign load    = i_q_valid && (!r_valid || i_ready);
    assign last    = (r_idx == i_bundle.count - 2'd1);
    assign o_pop   = load && last;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // present one result per beat
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_bundle.items[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

### hw/rtl/coin_transaction_stream_parser.sv
`timescale 1ns / 1ps
// Channel   Direction  Signals                      Beat
// input     in         i_valid, o_ready, i_data     one transaction byte
// output    out        o_valid, i_ready, o_data     one decoded field
// config    in         i_cfg_we, i_cfg_data         min_tx_bytes write
//
// The front parser takes one byte per cycle while the queue has room; each byte yields
// zero to three results. The back end sends one result per cycle while i_ready is high, so
// each result takes its own output beat; a four-entry queue between them absorbs bursts.
// Reset is synchronous, active low; min_tx_bytes returns to 60.
// Input stalls only when the queue is full; output stalls hold the result register.
module coin_transaction_stream_parser #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ctsp_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output ctsp_pkg::t_out_item o_data,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_data
);

    logic              q_ready, push, pop, q_valid;
    ctsp_pkg::t_bundle push_bundle, head_bundle;

    ctsp_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_bundle  (push_bundle)
    );

    ctsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_bundle(push_bundle),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_bundle(head_bundle)
    );

    ctsp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_bundle (head_bundle),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (o_data)
    );

endmodule

### sim/tb_coin_transaction_stream_parser.sv
`timescale 1ns / 1ps
module tb_coin_transaction_stream_parser;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    ctsp_pkg::t_in_item  i_data;
    logic                o_valid;
    logic                i_ready;
    ctsp_pkg::t_out_item o_data;
    logic                i_cfg_we;
    logic [7:0]          i_cfg_data;

    coin_transaction_stream_parser u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    ctsp_pkg::t_in_item  byte_q[$];
    ctsp_pkg::t_out_item field_q[$];
    int        fail_cnt;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        byte_taken;

    // parser shadow state
    ctsp_pkg::t_phase    sh_phase;
    int unsigned         sh_cnt;
    logic [63:0]         sh_acc;
    int unsigned         sh_vw;
    logic [31:0]         sh_total;
    logic [63:0]         sh_nin;
    logic [63:0]         sh_entry;
    logic [63:0]         sh_nout;
    logic [63:0]         sh_skip;
    logic [63:0]         sh_witleft;
    logic [63:0]         sh_witem;
    bit                  sh_seg;
    bit                  sh_zero;
    logic [7:0]          sh_min;
    ctsp_pkg::t_out_item step_fields[$];

    function automatic void clear_parser();
        sh_phase   = ctsp_pkg::PH_VERSION;
        sh_cnt     = 0;
        sh_acc     = '0;
        sh_vw      = 0;
        sh_total   = '0;
        sh_nin     = '0;
        sh_entry   = '0;
        sh_nout    = '0;
        sh_skip    = '0;
        sh_witleft = '0;
        sh_witem   = '0;
        sh_seg     = 1'b0;
        sh_zero    = 1'b0;
    endfunction

    function automatic void add_field(ctsp_pkg::t_kind k, logic [63:0] v, logic [63:0] ent,
                                      logic [4:0] pos, ctsp_pkg::t_err e);
        ctsp_pkg::t_out_item f;
        if (step_fields.size() < ctsp_pkg::MAX_RESULTS) begin
            f.field_kind    = k;
            f.field_value   = v;
            f.entry_number  = ent[31:0];
            f.byte_position = pos;
            f.error_code    = e;
            f.run_last      = 1'b0;
            step_fields = {step_fields, f};
        end
    endfunction

    function automatic bit take_compact(logic [7:0] b);
        if (sh_cnt == 0) begin
            if (b < 8'hFD) begin
                sh_acc = {56'd0, b};
                return 1'b1;
            end
            sh_vw  = (b == 8'hFD) ? 2 : (b == 8'hFE) ? 4 : 8;
            sh_acc = '0;
            sh_cnt = 1;
            return 1'b0;
        end
        sh_acc = sh_acc | ({56'd0, b} << (8 * ((sh_cnt - 1) & 7)));
        sh_cnt++;
        if (sh_cnt - 1 >= sh_vw) begin
            sh_cnt = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit take_le(logic [7:0] b, int unsigned n);
        if (sh_cnt == 0) sh_acc = '0;
        sh_acc = sh_acc | ({56'd0, b} << (8 * (sh_cnt & 7)));
        sh_cnt++;
        if (sh_cnt >= n) begin
            sh_cnt = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit count_ok();
        if (sh_acc[63:32] == 32'd0) return 1'b1;
        add_field(ctsp_pkg::K_ERROR, {32'd0, sh_total}, 0, 0, ctsp_pkg::E_TOO_LARGE);
        sh_phase = ctsp_pkg::PH_ERROR;
        return 1'b0;
    endfunction

    function automatic void end_outputs();
        sh_entry = '0;
        sh_phase = (sh_seg && sh_nin != 0) ? ctsp_pkg::PH_WITCOUNT : ctsp_pkg::PH_LOCKTIME;
    endfunction

    function automatic void next_out();
        sh_entry++;
        if (sh_entry >= sh_nout) end_outputs();
        else sh_phase = ctsp_pkg::PH_AMOUNT;
    endfunction

    function automatic void next_stack();
        sh_entry++;
        sh_phase = (sh_entry >= sh_nin) ? ctsp_pkg::PH_LOCKTIME : ctsp_pkg::PH_WITCOUNT;
    endfunction

    function automatic void after_wit_item();
        if (sh_witleft == 0) next_stack();
        else sh_phase = ctsp_pkg::PH_WITLEN;
    endfunction

    // decode one byte; a byte may be handed on to the next phase once
    function automatic void parse_byte(logic [7:0] b);
        bit again;
        logic [63:0] v;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            case (sh_phase)
                ctsp_pkg::PH_VERSION: begin
                    if (take_le(b, 4)) begin
                        add_field(ctsp_pkg::K_VERSION, sh_acc, 0, 0, ctsp_pkg::E_NONE);
                        sh_phase = ctsp_pkg::PH_MARKER;
                    end
                end
                ctsp_pkg::PH_MARKER: begin
                    if (b == 8'd0) begin
                        sh_zero  = 1'b1;
                        sh_phase = ctsp_pkg::PH_FLAG;
                    end else begin
                        sh_phase = ctsp_pkg::PH_INCOUNT;
                        again    = 1'b1;
                    end
                end
                ctsp_pkg::PH_FLAG: begin
                    sh_zero = 1'b0;
                    if (b == 8'd1) begin
                        sh_seg = 1'b1;
                        add_field(ctsp_pkg::K_WITNESS, 64'd1, 0, 0, ctsp_pkg::E_NONE);
                        sh_phase = ctsp_pkg::PH_INCOUNT;
                    end else begin
                        sh_nin = '0;
                        add_field(ctsp_pkg::K_INCOUNT, 64'd0, 0, 0, ctsp_pkg::E_NONE);
                        sh_phase = ctsp_pkg::PH_OUTCOUNT;
                        again    = 1'b1;
                    end
                end
                ctsp_pkg::PH_INCOUNT: begin
                    if (take_compact(b) && count_ok()) begin
                        sh_nin   = sh_acc;
                        sh_entry = '0;
                        add_field(ctsp_pkg::K_INCOUNT, sh_nin, 0, 0, ctsp_pkg::E_NONE);
                        sh_phase = (sh_nin == 0) ? ctsp_pkg::PH_OUTCOUNT : ctsp_pkg::PH_TXID;
                    end
                end
                ctsp_pkg::PH_TXID: begin
                    add_field(ctsp_pkg::K_TXID, {56'd0, b}, sh_entry,
                              5'(ctsp_pkg::TXID_BYTES - 1 - sh_cnt), ctsp_pkg::E_NONE);
                    sh_cnt++;
                    if (sh_cnt >= ctsp_pkg::TXID_BYTES) begin
                        sh_cnt   = 0;
                        sh_phase = ctsp_pkg::PH_PREVIDX;
                    end
                end
                ctsp_pkg::PH_PREVIDX: begin
                    if (take_le(b, 4)) begin
                        add_field(ctsp_pkg::K_PREVIDX, sh_acc, sh_entry, 0, ctsp_pkg::E_NONE);
                        sh_phase = ctsp_pkg::PH_SIGLEN;
                    end
                end
                ctsp_pkg::PH_SIGLEN: begin
                    if (take_compact(b) && count_ok()) begin
                        v = sh_acc;
                        add_field(ctsp_pkg::K_SIGLEN, v, sh_entry, 0, ctsp_pkg::E_NONE);
                        sh_skip  = v;
                        sh_phase = (v == 0) ? ctsp_pkg::PH_SEQ : ctsp_pkg::PH_SIGSKIP;
                    end
                end
                ctsp_pkg::PH_SIGSKIP: begin
                    sh_skip--;
                    if (sh_skip == 0) sh_phase = ctsp_pkg::PH_SEQ;
                end
                ctsp_pkg::PH_SEQ: begin
                    if (take_le(b, 4)) begin
                        add_field(ctsp_pkg::K_SEQ, sh_acc, sh_entry, 0, ctsp_pkg::E_NONE);
                        sh_entry++;
                        if (sh_entry >= sh_nin) begin
                            sh_entry = '0;
                            sh_phase = ctsp_pkg::PH_OUTCOUNT;
                        end else begin
                            sh_phase = ctsp_pkg::PH_TXID;
                        end
                    end
                end
                ctsp_pkg::PH_OUTCOUNT: begin
                    if (take_compact(b) && count_ok()) begin
                        sh_nout  = sh_acc;
                        sh_entry = '0;
                        add_field(ctsp_pkg::K_OUTCOUNT, sh_nout, 0, 0, ctsp_pkg::E_NONE);
                        if (sh_nout == 0) end_outputs();
                        else sh_phase = ctsp_pkg::PH_AMOUNT;
                    end
                end
                ctsp_pkg::PH_AMOUNT: begin
                    if (take_le(b, 8)) begin
                        add_field(ctsp_pkg::K_AMOUNT, sh_acc, sh_entry, 0, ctsp_pkg::E_NONE);
                        sh_phase = ctsp_pkg::PH_PKLEN;
                    end
                end
                ctsp_pkg::PH_PKLEN: begin
                    if (take_compact(b) && count_ok()) begin
                        v = sh_acc;
                        add_field(ctsp_pkg::K_PKLEN, v, sh_entry, 0, ctsp_pkg::E_NONE);
                        sh_skip = v;
                        if (v == 0) next_out();
                        else sh_phase = ctsp_pkg::PH_PKSKIP;
                    end
                end
                ctsp_pkg::PH_PKSKIP: begin
                    sh_skip--;
                    if (sh_skip == 0) next_out();
                end
                ctsp_pkg::PH_WITCOUNT: begin
                    if (take_compact(b) && count_ok()) begin
                        sh_witleft = sh_acc;
                        sh_witem   = '0;
                        add_field(ctsp_pkg::K_WITCOUNT, sh_witleft, sh_entry, 0,
                                  ctsp_pkg::E_NONE);
                        if (sh_witleft == 0) next_stack();
                        else sh_phase = ctsp_pkg::PH_WITLEN;
                    end
                end
                ctsp_pkg::PH_WITLEN: begin
                    if (take_compact(b) && count_ok()) begin
                        v = sh_acc;
                        add_field(ctsp_pkg::K_WITLEN, v, sh_witem, 0, ctsp_pkg::E_NONE);
                        sh_witem++;
                        sh_witleft--;
                        sh_skip = v;
                        if (v == 0) after_wit_item();
                        else sh_phase = ctsp_pkg::PH_WITSKIP;
                    end
                end
                ctsp_pkg::PH_WITSKIP: begin
                    sh_skip--;
                    if (sh_skip == 0) after_wit_item();
                end
                ctsp_pkg::PH_LOCKTIME: begin
                    if (take_le(b, 4)) begin
                        add_field(ctsp_pkg::K_LOCKTIME, sh_acc, 0, 0, ctsp_pkg::E_NONE);
                        sh_phase = ctsp_pkg::PH_TRAIL;
                    end
                end
                default: ;
            endcase
        end
    endfunction

    // predict the fields caused by one accepted beat
    function automatic void predict_fields(ctsp_pkg::t_in_item it);
        ctsp_pkg::t_phase entry_phase;
        entry_phase = sh_phase;
        step_fields.delete();
        if (sh_total != 32'hFFFF_FFFF) sh_total++;
        parse_byte(it.data_byte);
        if (it.end_of_tx) begin
            if (entry_phase != ctsp_pkg::PH_ERROR && sh_phase != ctsp_pkg::PH_ERROR) begin
                if (sh_phase == ctsp_pkg::PH_FLAG && sh_zero)
                    add_field(ctsp_pkg::K_INCOUNT, 64'd0, 0, 0, ctsp_pkg::E_NONE);
                if (sh_total < {24'd0, sh_min})
                    add_field(ctsp_pkg::K_ERROR, {32'd0, sh_total}, 0, 0, ctsp_pkg::E_SHORT);
                else if (entry_phase == ctsp_pkg::PH_TRAIL)
                    add_field(ctsp_pkg::K_ERROR, {32'd0, sh_total}, 0, 0,
                              ctsp_pkg::E_TRAILING);
                else if (sh_phase != ctsp_pkg::PH_TRAIL)
                    add_field(ctsp_pkg::K_ERROR, {32'd0, sh_total}, 0, 0, ctsp_pkg::E_EARLY);
                else
                    add_field(ctsp_pkg::K_DONE, {32'd0, sh_total}, 0, 0, ctsp_pkg::E_NONE);
            end
            clear_parser();
        end
        if (step_fields.size() > 0)
            step_fields[step_fields.size() - 1].run_last = 1'b1;
        foreach (step_fields[i]) field_q = {field_q, step_fields[i]};
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    // monitor: take input beats into the predictor, check output beats
    always @(posedge i_clk) begin
        ctsp_pkg::t_out_item e;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (field_q.size() == 0) begin
                    $error("unexpected field beat kind %0d", o_data.field_kind);
                    fail_cnt++;
                end else begin
                    e = field_q.pop_front();
                    check_field("field_kind", e.field_kind, o_data.field_kind);
                    check_field("field_value", e.field_value, o_data.field_value);
                    check_field("entry_number", e.entry_number, o_data.entry_number);
                    check_field("byte_position", e.byte_position, o_data.byte_position);
                    check_field("error_code", e.error_code, o_data.error_code);
                    check_field("run_last", e.run_last, o_data.run_last);
                end
            end
            if (i_valid && o_ready) begin
                predict_fields(i_data);
                byte_taken = 1'b1;
            end
        end
    end

    // driver: hold each byte until taken, idle and stall at random
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || byte_taken) begin
                byte_taken = 1'b0;
                if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_data  <= byte_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic put_byte(logic [7:0] b);
        ctsp_pkg::t_in_item it;
        it.data_byte = b;
        it.end_of_tx = 1'b0;
        byte_q = {byte_q, it};
    endtask

    task automatic put_le(logic [63:0] v, int n);
        for (int i = 0; i < n; i++) put_byte(v[8*i +: 8]);
    endtask

    // compact size, sometimes in a wider form than needed
    task automatic put_compact(logic [63:0] v);
        if (v < 253 && $urandom_range(5) != 0) begin
            put_byte(v[7:0]);
        end else if (v < 65536 && $urandom_range(1) == 0) begin
            put_byte(8'hFD);
            put_le(v, 2);
        end else if ($urandom_range(1) == 0) begin
            put_byte(8'hFE);
            put_le(v, 4);
        end else begin
            put_byte(8'hFF);
            put_le(v, 8);
        end
    endtask

    task automatic mark_end();
        byte_q[byte_q.size() - 1].end_of_tx = 1'b1;
    endtask

    // mode: 0 well formed, 1 cut short, 2 trailing bytes, 3 oversized count
    task automatic put_tx(bit seg, int nin, int nout, int mode);
        int start;
        int cut;
        start = byte_q.size();
        put_le({$urandom, $urandom}, 4);
        if (seg) begin
            put_byte(8'h00);
            put_byte(8'h01);
        end
        if (nin == 0 && !seg) put_byte(8'h00);
        else put_compact(nin);
        for (int i = 0; i < nin; i++) begin
            for (int j = 0; j < ctsp_pkg::TXID_BYTES; j++) put_byte($urandom_range(255));
            put_le($urandom, 4);
            cut = $urandom_range(3);
            put_compact(cut);
            for (int j = 0; j < cut; j++) put_byte($urandom_range(255));
            put_le($urandom, 4);
        end
        if (mode == 3) begin
            put_byte(8'hFF);
            put_le({$urandom_range(255, 1), 24'($urandom), $urandom}, 8);
            repeat ($urandom_range(3)) put_byte($urandom_range(255));
            mark_end();
            return;
        end
        put_compact(nout);
        for (int i = 0; i < nout; i++) begin
            put_le({$urandom, $urandom}, 8);
            cut = $urandom_range(3);
            put_compact(cut);
            for (int j = 0; j < cut; j++) put_byte($urandom_range(255));
        end
        if (seg) begin
            for (int i = 0; i < nin; i++) begin
                int items;
                items = $urandom_range(2);
                put_compact(items);
                for (int k = 0; k < items; k++) begin
                    cut = $urandom_range(3);
                    put_compact(cut);
                    for (int j = 0; j < cut; j++) put_byte($urandom_range(255));
                end
            end
        end
        put_le($urandom, 4);
        if (mode == 1) begin
            cut = $urandom_range(byte_q.size() - start - 1, 1);
            repeat (cut) void'(byte_q.pop_back());
        end else if (mode == 2) begin
            repeat ($urandom_range(3, 1)) put_byte($urandom_range(255));
        end
        mark_end();
    endtask

    task automatic wait_idle();
        while (byte_q.size() != 0 || i_valid || field_q.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_min(logic [7:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sh_min = v;
    endtask

    initial begin
        int idle_set[4];
        int stall_set[4];
        logic [7:0] min_set[4];
        int sent;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_data         = '0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        fail_cnt       = 0;
        byte_taken     = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sh_min         = ctsp_pkg::MIN_TX_RESET;
        clear_parser();
        idle_set  = '{0, 77, 0, 31};
        stall_set = '{0, 0, 77, 31};
        min_set   = '{8'd60, 8'd0, 8'd255, 8'($urandom_range(40, 120))};
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extreme bytes, lone zero as count and as last byte
        put_le(64'hFFFF_FFFF, 4);
        put_byte(8'h00);
        put_byte(8'h00);
        put_le(64'h0, 4);
        mark_end();
        put_le(64'h0, 4);
        put_byte(8'h00);
        mark_end();
        // witness flag with no inputs, then a trailing byte
        put_le(64'h1, 4);
        put_byte(8'h00);
        put_byte(8'h01);
        put_byte(8'h00);
        put_byte(8'h00);
        put_le(64'h0, 4);
        put_byte(8'hFF);
        mark_end();
        // oversized input count, ended early
        put_le(64'h2, 4);
        put_byte(8'hFF);
        put_le(64'hFFFF_FFFF_FFFF_FFFF, 8);
        mark_end();
        put_byte(8'hAA);
        put_byte(8'h55);
        mark_end();

        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            if (ph != 0) write_min(min_set[ph]);
            send_idle_pct  = idle_set[ph];
            recv_stall_pct = stall_set[ph];
            sent = 0;
            while (sent < 20) begin
                int before_n;
                int r;
                before_n = byte_q.size();
                r = $urandom_range(9);
                put_tx($urandom_range(1), $urandom_range(1), $urandom_range(1),
                       (r < 6) ? 0 : r - 6 + ((r == 9) ? 0 : 1));
                sent += byte_q.size() - before_n;
            end
        end
        wait_idle();
        if (fail_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
